[hw/rtl/tcws_pkg.sv]
`timescale 1ns / 1ps

package tcws_pkg;

   localparam int COORD_BITS = 12;
   localparam int DIM_W      = 14;
   localparam int DDIM_W     = 13;
   localparam int PCT_W      = 7;
   localparam int OUT_W      = 16;
   localparam int WORK_W     = 40;
   localparam int MUL_A_W    = 32;
   localparam int MUL_B_W    = 32;
   localparam int PROD_W     = 64;
   localparam int DIVN_W     = WORK_W;
   localparam int DIVD_W     = DIM_W;
   localparam int DIV_CNT_W  = $clog2(DIVN_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [CSR_IDX_W-1:0] REG_MAIN_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAIN_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DETECT_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DETECT_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POS_THR       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_THR      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MARGIN        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED         = 3'd7;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   typedef struct packed {
      logic [DIM_W-1:0] mw;
      logic [DIM_W-1:0] mh;
      logic [DIM_W-1:0] dw;
      logic [DIM_W-1:0] dh;
      logic [PCT_W-1:0] pthr;
      logic [PCT_W-1:0] sthr;
      logic [PCT_W-1:0] marg;
      logic [PCT_W-1:0] spd;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
   } box_type;

   typedef struct packed {
      logic [OUT_W-1:0] x;
      logic [OUT_W-1:0] y;
      logic [OUT_W-1:0] w;
      logic [OUT_W-1:0] h;
   } crop_rect_type;

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

[hw/rtl/tcws_divider.sv]
`timescale 1ns / 1ps

module tcws_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tcws_pkg::DIVN_W-1:0]   dividend,
   input  logic [tcws_pkg::DIVD_W-1:0]   divisor,
   output logic                          done,
   output logic [tcws_pkg::DIVN_W-1:0]   quotient
);
   import tcws_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVN_W-1:0]    quo_ff, quo_in;
   logic [DIVD_W-1:0]    rem_ff, rem_in;
   logic [DIVD_W-1:0]    den_ff, den_in;
   logic [DIVD_W:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[DIVN_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIVD_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIVN_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVD_W-1:0];
            quo_in = {quo_ff[DIVN_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIVN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/tcws_engine.sv]
`timescale 1ns / 1ps

module tcws_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  tcws_pkg::cfg_type       cfg,
   input  logic                    start,
   input  tcws_pkg::box_type       box,
   output logic                    idle,
   output logic                    res_valid,
   output tcws_pkg::crop_rect_type res,
   input  logic                    res_take
);
   import tcws_pkg::*;

   typedef enum logic [3:0] {
      E_IDLE = 4'b0001,
      E_EXEC = 4'b0010,
      E_DIVW = 4'b0100,
      E_HOLD = 4'b1000
   } eng_state_type;

   localparam logic [5:0] S_PTHR_MUL = 6'd0;
   localparam logic [5:0] S_PTHR_DIV = 6'd1;
   localparam logic [5:0] S_SW_MUL   = 6'd2;
   localparam logic [5:0] S_SW_DIV   = 6'd3;
   localparam logic [5:0] S_SH_MUL   = 6'd4;
   localparam logic [5:0] S_SH_DIV   = 6'd5;
   localparam logic [5:0] S_MV_FIRST = 6'd6;
   localparam logic [5:0] S_MV_LAST  = 6'd13;
   localparam logic [5:0] S_ASP_W    = 6'd14;
   localparam logic [5:0] S_ASP_H    = 6'd15;
   localparam logic [5:0] S_ASP_DIV  = 6'd16;
   localparam logic [5:0] S_OFS_MUL  = 6'd17;
   localparam logic [5:0] S_MW_MUL   = 6'd18;
   localparam logic [5:0] S_MW_DIV   = 6'd19;
   localparam logic [5:0] S_MH_MUL   = 6'd20;
   localparam logic [5:0] S_MH_DIV   = 6'd21;
   localparam logic [5:0] S_CLX      = 6'd22;
   localparam logic [5:0] S_FH_MUL   = 6'd23;
   localparam logic [5:0] S_FH_DIV   = 6'd24;
   localparam logic [5:0] S_CLY      = 6'd25;
   localparam logic [5:0] S_FW_MUL   = 6'd26;
   localparam logic [5:0] S_FW_DIV   = 6'd27;
   localparam logic [5:0] S_WC_DIV   = 6'd28;
   localparam logic [5:0] S_HC_DIV   = 6'd29;
   localparam logic [5:0] S_OX_MUL   = 6'd30;
   localparam logic [5:0] S_OY_MUL   = 6'd31;
   localparam logic [5:0] S_OW_MUL   = 6'd32;
   localparam logic [5:0] S_OH_MUL   = 6'd33;

   localparam logic [MUL_B_W-1:0] OFS_MUL_K   = MUL_B_W'(3);
   localparam logic [MUL_B_W-1:0] RECIP_25    = 32'h51EB851F;
   localparam int                 RECIP_SHIFT = 35;
   localparam logic [WORK_W-1:0]  ROUND_UP    = 40'd99;
   localparam int                 PAD_C       = WORK_W - COORD_BITS;
   localparam int                 PAD_D       = WORK_W - DIM_W;

   eng_state_type          state_ff, state_in;
   logic [5:0]             step_ff, step_in;
   box_type                box_ff, box_in;
   logic [COORD_BITS-1:0]  tgt_ff [4];
   logic [COORD_BITS-1:0]  tgt_in [4];
   logic [COORD_BITS-1:0]  cur_ff [4];
   logic [COORD_BITS-1:0]  cur_in [4];
   logic [WORK_W-1:0]      p_ff, p_in;
   logic [WORK_W-1:0]      t0_ff, t0_in;
   logic [WORK_W-1:0]      t1_ff, t1_in;
   logic signed [WORK_W-1:0] wd_ff, wd_in, ht_ff, ht_in, x_ff, x_in, y_ff, y_in;
   logic                   fix_ff, fix_in;
   crop_rect_type          res_ff, res_in;

   logic                   is_div;
   logic                   pct_div;
   logic                   wb;
   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [PROD_W-1:0]      prod;
   logic [DIVN_W-1:0]      div_n;
   logic [DIVD_W-1:0]      div_d;
   logic                   div_start;
   logic                   div_done;
   logic [DIVN_W-1:0]      div_q;
   logic [DIVN_W-1:0]      q100;
   logic [DIVN_W-1:0]      q;
   logic signed [WORK_W-1:0] qs, xm, ym, dwx, dhx, cx, cy, off;
   logic [5:0]             mv_off;
   logic [1:0]             lane;
   logic [COORD_BITS-1:0]  lane_d;
   logic                   asp_h;
   logic [OUT_W-1:0]       sat;

   tcws_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      mv_off  = step_ff - S_MV_FIRST;
      lane    = mv_off[2:1];
      lane_d  = abs_diff(tgt_ff[lane], cur_ff[lane]);
      asp_h   = (t0_ff < t1_ff);
      is_div  = 1'b0;
      pct_div = 1'b0;
      mul_a   = '0;
      mul_b   = '0;
      div_n   = p_ff;
      div_d   = DIVD_W'(PCT_FULL);
      case (step_ff) inside
         S_PTHR_MUL: begin
            mul_a = MUL_A_W'(({1'b0, box_ff.w} + {1'b0, box_ff.h}) >> 1);
            mul_b = MUL_B_W'(cfg.pthr);
         end
         S_SW_MUL: begin
            mul_a = MUL_A_W'(box_ff.w);
            mul_b = MUL_B_W'(cfg.sthr);
         end
         S_SH_MUL: begin
            mul_a = MUL_A_W'(box_ff.h);
            mul_b = MUL_B_W'(cfg.sthr);
         end
         S_PTHR_DIV, S_SW_DIV, S_SH_DIV, S_MW_DIV, S_MH_DIV: pct_div = 1'b1;
         [S_MV_FIRST:S_MV_LAST]: begin
            if (mv_off[0]) begin
               pct_div = 1'b1;
            end else begin
               mul_a = MUL_A_W'(lane_d);
               mul_b = MUL_B_W'(cfg.spd);
            end
         end
         S_ASP_W: begin
            mul_a = MUL_A_W'(cur_ff[2]);
            mul_b = MUL_B_W'(cfg.mh);
         end
         S_ASP_H: begin
            mul_a = MUL_A_W'(cur_ff[3]);
            mul_b = MUL_B_W'(cfg.mw);
         end
         S_ASP_DIV: begin
            is_div = 1'b1;
            div_n  = asp_h ? t1_ff : t0_ff;
            div_d  = asp_h ? cfg.mh : cfg.mw;
         end
         S_OFS_MUL: begin
            mul_a = (wd_ff >= ht_ff) ? MUL_A_W'(wd_ff - ht_ff) : MUL_A_W'(ht_ff - wd_ff);
            mul_b = OFS_MUL_K;
         end
         S_MW_MUL: begin
            mul_a = wd_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(cfg.marg);
         end
         S_MH_MUL: begin
            mul_a = ht_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(cfg.marg);
         end
         S_FH_MUL: begin
            mul_a = wd_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(cfg.mh);
         end
         S_FH_DIV: begin
            is_div = 1'b1;
            div_d  = cfg.mw;
         end
         S_FW_MUL: begin
            mul_a = ht_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(cfg.mw);
         end
         S_FW_DIV: begin
            is_div = 1'b1;
            div_d  = cfg.mh;
         end
         S_WC_DIV: begin
            is_div = 1'b1;
            div_n  = DIVN_W'(cfg.mw);
            div_d  = cfg.dw;
         end
         S_HC_DIV: begin
            is_div = 1'b1;
            div_n  = DIVN_W'(cfg.mh);
            div_d  = cfg.dh;
         end
         S_OX_MUL: begin
            mul_a = x_ff[MUL_A_W-1:0];
            mul_b = t0_ff[MUL_B_W-1:0];
         end
         S_OY_MUL: begin
            mul_a = y_ff[MUL_A_W-1:0];
            mul_b = t1_ff[MUL_B_W-1:0];
         end
         S_OW_MUL: begin
            mul_a = wd_ff[MUL_A_W-1:0];
            mul_b = t0_ff[MUL_B_W-1:0];
         end
         S_OH_MUL: begin
            mul_a = ht_ff[MUL_A_W-1:0];
            mul_b = t1_ff[MUL_B_W-1:0];
         end
         default: ;
      endcase
      // divide by 100 as (n >> 2) / 25, the latter through the reciprocal of 25
      if (pct_div) begin
         mul_a = MUL_A_W'(p_ff >> 2);
         mul_b = RECIP_25;
      end
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign sat  = (prod > PROD_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : prod[OUT_W-1:0];
   assign q100 = DIVN_W'(prod >> RECIP_SHIFT);
   assign q    = pct_div ? q100 : div_q;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      box_in    = box_ff;
      tgt_in    = tgt_ff;
      cur_in    = cur_ff;
      p_in      = p_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      wd_in     = wd_ff;
      ht_in     = ht_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      fix_in    = fix_ff;
      res_in    = res_ff;
      div_start = 1'b0;
      wb        = 1'b0;
      qs        = $signed(q);
      dwx       = $signed({{PAD_D{1'b0}}, cfg.dw});
      dhx       = $signed({{PAD_D{1'b0}}, cfg.dh});
      cx        = $signed({{PAD_C{1'b0}}, cur_ff[0]});
      cy        = $signed({{PAD_C{1'b0}}, cur_ff[1]});
      off       = $signed(WORK_W'(prod >> 2));
      xm        = x_ff - qs;
      ym        = y_ff - qs;

      case (state_ff)
         E_IDLE: begin
            if (start) begin
               box_in   = box;
               step_in  = S_PTHR_MUL;
               state_in = E_EXEC;
            end
         end
         E_EXEC: begin
            if (is_div) begin
               div_start = 1'b1;
               state_in  = E_DIVW;
            end else begin
               wb = 1'b1;
            end
         end
         E_DIVW: wb = div_done;
         E_HOLD: begin
            if (res_take) state_in = E_IDLE;
         end
         default: state_in = E_IDLE;
      endcase

      if (wb) begin
         if (step_ff == S_OH_MUL) begin
            state_in = E_HOLD;
         end else begin
            step_in  = step_ff + 1'b1;
            state_in = E_EXEC;
         end
         case (step_ff) inside
            S_PTHR_MUL, S_SW_MUL, S_SH_MUL, S_MW_MUL, S_MH_MUL, S_FH_MUL, S_FW_MUL:
               p_in = prod[WORK_W-1:0];
            S_PTHR_DIV: begin
               if (box_ff.valid &&
                   ((WORK_W'(abs_diff(tgt_ff[0], box_ff.x)) > q) ||
                    (WORK_W'(abs_diff(tgt_ff[1], box_ff.y)) > q))) begin
                  tgt_in[0] = box_ff.x;
                  tgt_in[1] = box_ff.y;
               end
            end
            S_SW_DIV: t0_in = q;
            S_SH_DIV: begin
               if (box_ff.valid &&
                   ((WORK_W'(abs_diff(tgt_ff[2], box_ff.w)) > t0_ff) ||
                    (WORK_W'(abs_diff(tgt_ff[3], box_ff.h)) > q))) begin
                  tgt_in[2] = box_ff.w;
                  tgt_in[3] = box_ff.h;
               end
            end
            [S_MV_FIRST:S_MV_LAST]: begin
               if (!mv_off[0]) begin
                  p_in = prod[WORK_W-1:0] + ROUND_UP;
               end else if (tgt_ff[lane] > cur_ff[lane]) begin
                  cur_in[lane] = cur_ff[lane] + q[COORD_BITS-1:0];
               end else begin
                  cur_in[lane] = cur_ff[lane] - q[COORD_BITS-1:0];
               end
            end
            S_ASP_W: t0_in = prod[WORK_W-1:0];
            S_ASP_H: t1_in = prod[WORK_W-1:0];
            S_ASP_DIV: begin
               if (asp_h) begin
                  wd_in = qs;
                  ht_in = $signed({{PAD_C{1'b0}}, cur_ff[3]});
               end else begin
                  wd_in = $signed({{PAD_C{1'b0}}, cur_ff[2]});
                  ht_in = qs;
               end
            end
            S_OFS_MUL: begin
               if (wd_ff >= ht_ff) begin
                  x_in = cx - off;
                  y_in = cy;
               end else begin
                  x_in = cx;
                  y_in = cy - off;
               end
            end
            S_MW_DIV: begin
               x_in  = (xm < 0) ? '0 : xm;
               wd_in = wd_ff + (qs <<< 1);
            end
            S_MH_DIV: begin
               y_in  = (ym < 0) ? '0 : ym;
               ht_in = ht_ff + (qs <<< 1);
            end
            S_CLX: begin
               fix_in = 1'b0;
               if (x_ff + wd_ff > dwx) begin
                  if (dwx - wd_ff < 0) begin
                     wd_in  = dwx;
                     x_in   = '0;
                     fix_in = 1'b1;
                  end else begin
                     x_in = dwx - wd_ff;
                  end
               end
            end
            S_FH_DIV: if (fix_ff) ht_in = qs;
            S_CLY: begin
               fix_in = 1'b0;
               if (y_ff + ht_ff > dhx) begin
                  if (dhx - ht_ff < 0) begin
                     ht_in  = dhx;
                     y_in   = '0;
                     fix_in = 1'b1;
                  end else begin
                     y_in = dhx - ht_ff;
                  end
               end
            end
            S_FW_DIV: if (fix_ff) wd_in = qs;
            S_WC_DIV: t0_in = q;
            S_HC_DIV: t1_in = q;
            S_OX_MUL: res_in.x = sat;
            S_OY_MUL: res_in.y = sat;
            S_OW_MUL: res_in.w = sat;
            S_OH_MUL: res_in.h = sat;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         step_ff  <= S_PTHR_MUL;
         for (int i = 0; i < 4; i++) begin
            tgt_ff[i] <= '0;
            cur_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         tgt_ff   <= tgt_in;
         cur_ff   <= cur_in;
      end
      box_ff <= box_in;
      p_ff   <= p_in;
      t0_ff  <= t0_in;
      t1_ff  <= t1_in;
      wd_ff  <= wd_in;
      ht_ff  <= ht_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      fix_ff <= fix_in;
      res_ff <= res_in;
   end

   assign idle      = (state_ff == E_IDLE);
   assign res_valid = (state_ff == E_HOLD);
   assign res       = res_ff;

endmodule

[hw/rtl/tracking_crop_window_smoother.sv]
`timescale 1ns / 1ps

// Crop window smoother for a tracking camera.
// req_* carries one detection beat per video frame: req_tuser is the box
// valid flag, req_tdata the box in detector pixels. rsp_* returns one crop
// rectangle in main-stream pixels for every request beat, in order.
// csr_* writes the eight setup registers (index 0..7); write only while
// no request is in flight.
// For each beat the sequencer runs 34 steps over one shared 32x32
// multiplier and one bit-serial divider. Percent scaling goes through
// the multiplier as a reciprocal product in one step; the divider runs
// five times, for the aspect, refit and scale quotients. The result
// appears on rsp once the sequencer has finished and the rsp register is
// free, and req_tready rises again in that same cycle.
// req_tready is high only while the sequencer is idle. A finished crop
// moves into the rsp output register; while that register waits on a
// stalled receiver the next request is still taken and computed, and its
// result holds in the sequencer until the register frees up.
// Synchronous reset restores the register defaults (3840x2160 main,
// 640x360 detector, 6/13/5/15 percent) and zeros the stored target and
// window.

module tracking_crop_window_smoother (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // box_x, box_y, box_w, box_h
   input  logic        req_tuser,   // box_valid
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // crop_x, crop_y, crop_w, crop_h
   input  logic        csr_we,
   input  logic [tcws_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [tcws_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tcws_pkg::*;

   logic [DIM_W-1:0]  main_w_ff, main_h_ff;
   logic [DDIM_W-1:0] det_w_ff, det_h_ff;
   logic [PCT_W-1:0]  pthr_ff, sthr_ff, marg_ff, spd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   crop_rect_type     rsp_ff, rsp_in;

   cfg_type       cfg;
   box_type       box;
   logic          eng_idle;
   logic          eng_valid;
   crop_rect_type eng_res;
   logic          eng_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_w_ff <= 14'd3840;
         main_h_ff <= 14'd2160;
         det_w_ff  <= 13'd640;
         det_h_ff  <= 13'd360;
         pthr_ff   <= 7'd6;
         sthr_ff   <= 7'd13;
         marg_ff   <= 7'd5;
         spd_ff    <= 7'd15;
      end else if (csr_we) begin
         case (csr_addr)
            REG_MAIN_WIDTH:    main_w_ff <= csr_wdata;
            REG_MAIN_HEIGHT:   main_h_ff <= csr_wdata;
            REG_DETECT_WIDTH:  det_w_ff  <= csr_wdata[DDIM_W-1:0];
            REG_DETECT_HEIGHT: det_h_ff  <= csr_wdata[DDIM_W-1:0];
            REG_POS_THR:       pthr_ff   <= csr_wdata[PCT_W-1:0];
            REG_SIZE_THR:      sthr_ff   <= csr_wdata[PCT_W-1:0];
            REG_MARGIN:        marg_ff   <= csr_wdata[PCT_W-1:0];
            REG_SPEED:         spd_ff    <= csr_wdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // zero dimensions act as one; speed saturates at full step
   always_comb begin
      cfg.mw   = (main_w_ff == '0) ? DIM_W'(1) : main_w_ff;
      cfg.mh   = (main_h_ff == '0) ? DIM_W'(1) : main_h_ff;
      cfg.dw   = (det_w_ff == '0) ? DIM_W'(1) : DIM_W'(det_w_ff);
      cfg.dh   = (det_h_ff == '0) ? DIM_W'(1) : DIM_W'(det_h_ff);
      cfg.pthr = pthr_ff;
      cfg.sthr = sthr_ff;
      cfg.marg = marg_ff;
      cfg.spd  = (spd_ff > PCT_FULL) ? PCT_FULL : spd_ff;
   end

   always_comb begin
      box.valid = req_tuser;
      box.x     = req_tdata[11:0];
      box.y     = req_tdata[23:12];
      box.w     = req_tdata[35:24];
      box.h     = req_tdata[47:36];
   end

   tcws_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .start     (req_tvalid && req_tready),
      .box       (box),
      .idle      (eng_idle),
      .res_valid (eng_valid),
      .res       (eng_res),
      .res_take  (eng_take)
   );

   assign req_tready = eng_idle;
   assign eng_take   = eng_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (eng_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.h, rsp_ff.w, rsp_ff.y, rsp_ff.x};

endmodule

[hw/rtl/tcws_checker.sv]
`timescale 1ns / 1ps

module tcws_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed under stall");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

   // an accepted request keeps the sequencer busy
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while sequencer busy");

   // a request taken while rsp is empty must not raise rsp_tvalid too soon
   a_req_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##2 !$rose(rsp_tvalid))
      else $error("result appeared too soon after request");

endmodule

bind tracking_crop_window_smoother tcws_checker u_tcws_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sv/tracking_crop_window_smoother_tb.sv]
`timescale 1ns / 1ps

module tracking_crop_window_smoother_tb;
   import tcws_pkg::*;

   typedef struct {
      logic        valid;
      logic [47:0] box;
   } det_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = REG_MAIN_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tracking_crop_window_smoother uut (.*);

   always #5 clock = ~clock;

   det_beat_type pending_dets[$];
   logic [63:0] expected_crops[$];
   int errors = 0;
   int beats_sent = 0;
   bit req_taken = 1'b0;

   // shadow of the setup registers and of the tracking state
   longint sh_mw, sh_mh, sh_dw, sh_dh, sh_pthr, sh_sthr, sh_marg, sh_spd;
   longint tgt[4], cur[4];

   function automatic longint adiff(longint a, longint b);
      return a > b ? a - b : b - a;
   endfunction

   function automatic logic [15:0] clip16(longint v);
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hFFFF;
      return v[15:0];
   endfunction

   task automatic shadow_defaults();
      sh_mw = 3840; sh_mh = 2160; sh_dw = 640; sh_dh = 360;
      sh_pthr = 6; sh_sthr = 13; sh_marg = 5; sh_spd = 15;
      for (int i = 0; i < 4; i++) begin
         tgt[i] = 0;
         cur[i] = 0;
      end
   endtask

   // advance the tracker by one detection and return the crop it yields
   function automatic logic [63:0] track_and_crop(logic valid, logic [47:0] box);
      longint mw, mh, dw, dh, spd, bx, by, bw, bh, pthr, d, m;
      longint wd, ht, x, y, cw, ch, wc, hc;
      mw = sh_mw == 0 ? 1 : sh_mw;
      mh = sh_mh == 0 ? 1 : sh_mh;
      dw = sh_dw == 0 ? 1 : sh_dw;
      dh = sh_dh == 0 ? 1 : sh_dh;
      spd = sh_spd > 100 ? 100 : sh_spd;
      if (valid) begin
         bx = box[11:0]; by = box[23:12]; bw = box[35:24]; bh = box[47:36];
         pthr = ((bw + bh) / 2) * sh_pthr / 100;
         if (adiff(tgt[0], bx) > pthr || adiff(tgt[1], by) > pthr) begin
            tgt[0] = bx;
            tgt[1] = by;
         end
         if (adiff(tgt[2], bw) > bw * sh_sthr / 100 ||
             adiff(tgt[3], bh) > bh * sh_sthr / 100) begin
            tgt[2] = bw;
            tgt[3] = bh;
         end
      end
      for (int i = 0; i < 4; i++) begin
         d = adiff(tgt[i], cur[i]);
         m = (d * spd + 99) / 100;
         if (tgt[i] > cur[i]) cur[i] += m;
         else cur[i] -= m;
      end
      if (cur[2] * mh < cur[3] * mw) begin
         wd = cur[3] * mw / mh;
         ht = cur[3];
      end else begin
         wd = cur[2];
         ht = cur[2] * mh / mw;
      end
      if (wd >= ht) begin
         x = cur[0] - (wd - ht) * 3 / 4;
         y = cur[1];
      end else begin
         x = cur[0];
         y = cur[1] - (ht - wd) * 3 / 4;
      end
      cw = wd * sh_marg / 100;
      ch = ht * sh_marg / 100;
      x -= cw;
      y -= ch;
      wd += 2 * cw;
      ht += 2 * ch;
      if (x < 0) x = 0;
      if (y < 0) y = 0;
      if (x + wd > dw) begin
         x = dw - wd;
         if (x < 0) begin
            wd = dw;
            x = 0;
            ht = wd * mh / mw;
         end
      end
      if (y + ht > dh) begin
         y = dh - ht;
         if (y < 0) begin
            ht = dh;
            y = 0;
            wd = ht * mw / mh;
         end
      end
      wc = mw / dw;
      hc = mh / dh;
      return {clip16(ht * hc), clip16(wd * wc), clip16(y * hc), clip16(x * wc)};
   endfunction

   // idle profile moves with the number of beats already sent
   function automatic bit sender_idles();
      if (beats_sent < 270) return $urandom_range(99) < 13;
      if (beats_sent < 540) return $urandom_range(99) < 72;
      return 1'b0;
   endfunction

   function automatic bit receiver_idles();
      if (beats_sent < 270) return $urandom_range(99) < 72;
      if (beats_sent < 540) return $urandom_range(99) < 13;
      return 1'b0;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !receiver_idles();
         if (!req_tvalid || req_taken) begin
            if (pending_dets.size() > 0 && !sender_idles()) begin
               det_beat_type b;
               b = pending_dets.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= b.valid;
               req_tdata <= b.box;
               beats_sent++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            expected_crops.push_back(track_and_crop(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_crops.size() == 0) begin
               $error("crop beat with no detection outstanding: %h", rsp_tdata);
               errors++;
            end else begin
               logic [63:0] want;
               want = expected_crops.pop_front();
               for (int f = 0; f < 4; f++) begin
                  if (want[f*16 +: 16] !== rsp_tdata[f*16 +: 16]) begin
                     $error("%s expected %0d got %0d",
                            f == 0 ? "crop_x" : f == 1 ? "crop_y" :
                            f == 2 ? "crop_w" : "crop_h",
                            want[f*16 +: 16], rsp_tdata[f*16 +: 16]);
                     errors++;
                  end
               end
            end
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      case (idx)
         REG_MAIN_WIDTH:    sh_mw = val & 'h3FFF;
         REG_MAIN_HEIGHT:   sh_mh = val & 'h3FFF;
         REG_DETECT_WIDTH:  sh_dw = val & 'h1FFF;
         REG_DETECT_HEIGHT: sh_dh = val & 'h1FFF;
         REG_POS_THR:       sh_pthr = val & 'h7F;
         REG_SIZE_THR:      sh_sthr = val & 'h7F;
         REG_MARGIN:        sh_marg = val & 'h7F;
         default:           sh_spd = val & 'h7F;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic setup(int mw, int mh, int dw, int dh, int pt, int st, int mg, int sp);
      csr_write(REG_MAIN_WIDTH, mw);
      csr_write(REG_MAIN_HEIGHT, mh);
      csr_write(REG_DETECT_WIDTH, dw);
      csr_write(REG_DETECT_HEIGHT, dh);
      csr_write(REG_POS_THR, pt);
      csr_write(REG_SIZE_THR, st);
      csr_write(REG_MARGIN, mg);
      csr_write(REG_SPEED, sp);
   endtask

   task automatic push_det(logic valid, int x, int y, int w, int h);
      det_beat_type b;
      b.valid = valid;
      b.box = {h[11:0], w[11:0], y[11:0], x[11:0]};
      pending_dets.push_back(b);
   endtask

   task automatic drain();
      wait (pending_dets.size() == 0 && !req_tvalid && expected_crops.size() == 0);
      @(negedge clock);
   endtask

   // mostly a target drifting with jitter, with occasional jumps, dropouts and noise
   task automatic push_track(int n, int span);
      int x, y, w, h, r;
      x = $urandom_range(span); y = $urandom_range(span);
      w = $urandom_range(span) + 1; h = $urandom_range(span) + 1;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 8) begin
            push_det(1'b0, $urandom, $urandom, $urandom, $urandom);
         end else if (r < 16) begin
            push_det(1'b1, $urandom, $urandom, $urandom, $urandom);
         end else begin
            if (r < 26) begin
               x = $urandom_range(span); y = $urandom_range(span);
               w = $urandom_range(span) + 1; h = $urandom_range(span) + 1;
            end
            x = (x + $urandom_range(20) - 10) & 'hFFF;
            y = (y + $urandom_range(20) - 10) & 'hFFF;
            w = (w + $urandom_range(16) - 8) & 'hFFF;
            h = (h + $urandom_range(16) - 8) & 'hFFF;
            push_det(1'b1, x, y, w, h);
         end
      end
   endtask

   initial begin
      shadow_defaults();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: defaults, field extremes, dropouts, settling on a still box
      push_det(1'b0, 0, 0, 0, 0);
      push_det(1'b1, 0, 0, 0, 0);
      push_det(1'b1, 4095, 4095, 4095, 4095);
      push_det(1'b0, 4095, 4095, 4095, 4095);
      push_det(1'b1, 100, 80, 60, 120);
      repeat (4) push_det(1'b1, 102, 81, 62, 121);
      push_det(1'b1, 4095, 0, 1, 4095);
      push_det(1'b1, 0, 4095, 4095, 1);
      push_det(1'b1, 300, 200, 40, 30);
      repeat (3) push_det(1'b0, 0, 0, 0, 0);
      push_det(1'b1, 620, 340, 200, 200);
      push_det(1'b1, 1, 1, 700, 400);
      drain();

      // extremes: large frames, zero thresholds, full margin and speed
      setup(8192, 8192, 4096, 4096, 0, 0, 100, 100);
      push_det(1'b1, 4095, 4095, 4095, 4095);
      push_det(1'b1, 0, 0, 4095, 10);
      push_track(120, 4000);
      drain();

      // zero-valued dimensions act as one; out-of-range percentages
      setup(0, 0, 0, 0, 127, 127, 127, 127);
      push_det(1'b1, 50, 60, 70, 80);
      push_track(60, 300);
      drain();

      setup(1920, 1080, 640, 480, 6, 13, 5, 15);
      push_track(200, 600);
      drain();

      setup(8192, 1, 1, 4096, 100, 100, 0, 0);
      push_track(60, 500);
      drain();

      setup(3840, 2160, 640, 360, 6, 13, 5, 15);
      push_track(120, 640);
      drain();

      for (int p = 0; p < 3; p++) begin
         setup($urandom_range(8192, 1), $urandom_range(8192, 1), $urandom_range(4096, 1),
               $urandom_range(4096, 1), $urandom_range(30), $urandom_range(30),
               $urandom_range(20), $urandom_range(100, 1));
         push_track(60, 1500);
         drain();
      end

      repeat (700) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("FAIL");
      $finish;
   end

endmodule
